// ----- rtl/core/cbrm_pkg.sv -----
// Package for the convolution, bias, ReLU and max-pool block.
// Holds the transaction structs, command and register codes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package cbrm_pkg;

  localparam int N_OUT_DEF     = 16;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int QBITS_DEF     = 8;

  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;

  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_PIXEL  = 2'd2;

  localparam int OFD = 4;
  localparam int OAW = 2;
  localparam int OCW = 3;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         channel;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [10:0] out_row;
    logic [4:0]  out_col;
    logic [14:0] pooled;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/core/conv_bias_relu_maxpool.sv -----
// Top level: 1x1 convolution, bias, ReLU and 2x2 cover-all max pooling.
// Depends on cbrm_pkg and cbrm_ram (pool maxima store).
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid / in_stall  cbrm_pkg::in_item_t
//   out_*        out        out_valid / stall    cbrm_pkg::out_item_t
//   cfg_*        in         cfg_valid / ready    cfg_index, cfg_data
//
// A pixel holds the pool store's read and write ports while it issues, one channel a cycle
// while the output queue has room; the next pixel enters as its last channel issues.
// Weight, bias and unused transactions wait while a pixel is issuing.
// A result passes the issue stage registers into a 4-entry output queue that decouples.
// Reset clears weights, biases, position and image size to 16 x 12; the pool store
// needs no clearing. An output stall stops channel issue once the queue is full.
`timescale 1ns / 1ps

module conv_bias_relu_maxpool #(
  parameter int N_OUT     = cbrm_pkg::N_OUT_DEF,
  parameter int MAX_WIDTH = cbrm_pkg::MAX_WIDTH_DEF,
  parameter int QBITS     = cbrm_pkg::QBITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cbrm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cbrm_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cbrm_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [cbrm_pkg::CFG_DW-1:0]     cfg_data_i
);

  import cbrm_pkg::*;

  localparam int CHW       = (N_OUT > 1) ? $clog2(N_OUT) : 1;
  localparam int POOL_COLS = (MAX_WIDTH + 1) / 2;
  localparam int PCW       = (POOL_COLS > 1) ? $clog2(POOL_COLS) : 1;
  localparam int AW        = CHW + PCW;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int EW        = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;

  // configuration
  logic [6:0]  image_width_q;
  logic [12:0] image_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 7'd16;
      image_height_q <= 13'd12;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[6:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_w;
  logic [12:0]   eff_h;

  always_comb begin
    eff_w = EW'(image_width_q);
    if (eff_w == '0) begin
      eff_w = EW'(1);
    end else if (eff_w > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end
    eff_h = image_height_q;
    if (eff_h == '0) begin
      eff_h = 13'd1;
    end else if (eff_h > 13'(MAX_HEIGHT)) begin
      eff_h = 13'(MAX_HEIGHT);
    end
  end

  // input acceptance and channel issue
  logic              busy_q;
  logic [CHW-1:0]    ch_q;
  logic signed [15:0] px_val_q;
  logic [10:0]       px_row_q;
  logic [PCW-1:0]    px_pc_q;
  logic              px_start_q, px_done_q;
  logic [CW-1:0]     col_q, col_d;
  logic [11:0]       row_q, row_d;

  logic [OCW-1:0]    cnt_q;
  logic              s1_valid_q;
  logic              room, issue, last_issue, in_acc, px_load;

  assign room       = ({1'b0, cnt_q[OCW-2:0]} + OCW'(s1_valid_q) + OCW'(cnt_q[OCW-1] ? OFD : 0))
                      < OCW'(OFD);
  assign issue      = busy_q && room;
  assign last_issue = issue && (ch_q == CHW'(N_OUT - 1));
  assign in_stall_o = busy_q && !last_issue;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign px_load    = in_acc && (in_item_i.func == FUNC_PIXEL);

  logic          c_wrap;
  logic [CW-1:0] cur_c;
  logic [12:0]   r1, r2;
  logic [11:0]   cur_r;
  logic [EW-1:0] nc;
  logic          cur_start, cur_done;

  always_comb begin
    c_wrap = EW'(col_q) >= eff_w;
    cur_c  = c_wrap ? '0 : col_q;
    r1     = {1'b0, row_q} + 13'(c_wrap);
    cur_r  = (r1 >= eff_h) ? 12'd0 : r1[11:0];
    cur_start = !cur_r[0] && !cur_c[0];
    cur_done  = (cur_r[0] || ({1'b0, cur_r} == eff_h - 13'd1)) &&
                (cur_c[0] || (EW'(cur_c) == eff_w - EW'(1)));
    nc = EW'(cur_c) + EW'(1);
    r2 = {1'b0, cur_r} + 13'd1;
    if (nc >= eff_w) begin
      col_d = '0;
      row_d = (r2 >= eff_h) ? 12'd0 : r2[11:0];
    end else begin
      col_d = nc[CW-1:0];
      row_d = cur_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ch_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (px_load) begin
        busy_q <= 1'b1;
        ch_q   <= '0;
        col_q  <= col_d;
        row_q  <= row_d;
      end else if (last_issue) begin
        busy_q <= 1'b0;
      end else if (issue) begin
        ch_q <= ch_q + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_load) begin
      px_val_q   <= in_item_i.value;
      px_row_q   <= cur_r[11:1];
      px_pc_q    <= PCW'(cur_c >> 1);
      px_start_q <= cur_start;
      px_done_q  <= cur_done;
    end
  end

  // coefficients
  logic signed [15:0] weight_q [N_OUT];
  logic [15:0]        bias_q   [N_OUT];
  logic [6:0]         wr_ch;
  logic               coef_ok;

  assign wr_ch   = {3'b000, in_item_i.channel};
  assign coef_ok = in_acc && (wr_ch < 7'(N_OUT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_OUT; i++) begin
        weight_q[i] <= '0;
        bias_q[i]   <= '0;
      end
    end else if (coef_ok) begin
      if (in_item_i.func == FUNC_WEIGHT) begin
        weight_q[wr_ch[CHW-1:0]] <= in_item_i.value;
      end else if (in_item_i.func == FUNC_BIAS) begin
        bias_q[wr_ch[CHW-1:0]] <= in_item_i.value;
      end
    end
  end

  // issue stage: multiply, read the running maximum
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] s1_prod_q;
  logic [15:0]        s1_bias_q;
  logic [AW-1:0]      s1_addr_q;
  logic [CHW-1:0]     s1_ch_q;
  logic [10:0]        s1_row_q;
  logic [PCW-1:0]     s1_pc_q;
  logic               s1_start_q, s1_done_q;

  assign rd_addr = {ch_q, px_pc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_prod_q  <= px_val_q * weight_q[ch_q];
      s1_bias_q  <= bias_q[ch_q];
      s1_addr_q  <= rd_addr;
      s1_ch_q    <= ch_q;
      s1_row_q   <= px_row_q;
      s1_pc_q    <= px_pc_q;
      s1_start_q <= px_start_q;
      s1_done_q  <= px_done_q;
    end
  end

  // update stage: quantise, bias, ReLU, max and write back
  logic [15:0]        rdata, old_max, acc, sum, act, new_max;
  logic signed [31:0] shifted;
  logic               wr_en, fwd_hit_q;
  logic [15:0]        fwd_data_q;

  always_comb begin
    shifted = s1_prod_q >>> QBITS;
    acc     = shifted[15:0] - {15'd0, s1_prod_q[31]};
    sum     = acc + s1_bias_q;
    act     = sum[15] ? 16'd0 : sum;
    old_max = fwd_hit_q ? fwd_data_q : rdata;
    if (s1_start_q || (act > old_max)) begin
      new_max = act;
    end else begin
      new_max = old_max;
    end
  end

  assign wr_en = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= issue && wr_en && (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_max;
  end

  cbrm_ram #(
    .WIDTH (16),
    .DEPTH (2 ** AW)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_max),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // output queue
  out_item_t      oq_q [OFD];
  logic [OAW-1:0] wr_ptr_q, rd_ptr_q;
  logic           push, pop;
  out_item_t      res;

  always_comb begin
    res.out_channel = 4'(s1_ch_q);
    res.out_row     = s1_row_q;
    res.out_col     = 5'(s1_pc_q);
    res.pooled      = new_max[14:0];
    res.last        = (s1_ch_q == CHW'(N_OUT - 1));
  end

  assign push        = s1_valid_q && s1_done_q;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = oq_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OAW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + OCW'(1);
        2'b01:   cnt_q <= cnt_q - OCW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[wr_ptr_q] <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (4'(cnt_q) + 4'(s1_valid_q)) <= 4'(OFD))
    else $error("output queue overcommitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (cnt_q != OCW'(OFD)))
    else $error("push into full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_issue && !px_load) |=> !busy_q)
    else $error("channel issue continues past last channel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarded maximum without an update in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_valid_q)
    else $error("issued channel lost before update");

endmodule

// ----- rtl/core/cbrm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Read returns the old data on a same-address write. No dependencies.
`timescale 1ns / 1ps

module cbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
